// ===== hw/rtl/rgb_color_classifier_debounced_core_defines.svh =====
// ----------------------------------------------------------------------------
// RGB color classifier assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_COLOR_CLASSIFIER_DEBOUNCED_CORE_DEFINES_SVH
`define RGB_COLOR_CLASSIFIER_DEBOUNCED_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RGBCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RGBCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RGBCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RGBCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/rgbcc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB color classifier package
// Class codes, register indexes, reset values, rule thresholds and sequencer states.
// ----------------------------------------------------------------------------
package rgbcc_pkg;

    // class codes
    localparam int unsigned CODE_W = 3;
    localparam logic [CODE_W-1:0] CLS_NONE   = 3'd0;
    localparam logic [CODE_W-1:0] CLS_RED    = 3'd1;
    localparam logic [CODE_W-1:0] CLS_YELLOW = 3'd2;
    localparam logic [CODE_W-1:0] CLS_GREEN  = 3'd3;
    localparam logic [CODE_W-1:0] CLS_BLUE   = 3'd4;
    localparam logic [CODE_W-1:0] CLS_WHITE  = 3'd5;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WHITE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_RUNS = 2'd1;

    localparam int unsigned MIN_WHITE_W = 10;
    localparam int unsigned RUN_W       = 8;
    localparam logic [MIN_WHITE_W-1:0] MIN_WHITE_RESET = 10'd40;
    localparam logic [RUN_W-1:0]       CONFIRM_RESET   = 8'd5;
    localparam logic [RUN_W-1:0]       RUN_MAX         = 8'hFF;

    // ratio and rule constants
    localparam int unsigned RATIO_W   = 16;
    localparam int unsigned PROD_W    = RATIO_W + 3;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 16'hFFFF;
    localparam int unsigned PCT_SCALE    = 100;
    localparam int unsigned YELLOW_MIN_W = 100;
    localparam int unsigned GREEN_MAX_W  = 80;
    localparam int unsigned WHITE_MIN_W  = 200;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

// ===== hw/rtl/rgbcc_if.sv =====
// ----------------------------------------------------------------------------
// RGB color classifier channel interfaces
// Reading input, class output and register write channels.
// ----------------------------------------------------------------------------
interface rgbcc_in_if #(
    parameter int SAMPLE_BITS = 10
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] ambient_sample;
    logic [SAMPLE_BITS-1:0] red_sample;
    logic [SAMPLE_BITS-1:0] green_sample;
    logic [SAMPLE_BITS-1:0] blue_sample;
    logic [SAMPLE_BITS-1:0] white_sample;

    modport source (
        output valid, ambient_sample, red_sample, green_sample, blue_sample,
               white_sample,
        input  ready
    );
    modport sink (
        input  valid, ambient_sample, red_sample, green_sample, blue_sample,
               white_sample,
        output ready
    );
endinterface

interface rgbcc_out_if import rgbcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] color_code;

    modport source (output valid, color_code, input ready);
    modport sink (input valid, color_code, output ready);
endinterface

interface rgbcc_cfg_if import rgbcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rgb_color_classifier_debounced_core.sv =====
// ----------------------------------------------------------------------------
// Sequencing: an accepted reading passes through S_PREP, then S_DIV for the red,
//   green and blue ratios, then S_DONE; a dim reading goes from S_PREP to S_DONE.
// Flow: one reading set at a time; a new set is accepted only in S_IDLE, and
//   the one serial divider forms the red, green and blue ratios in turn.
// Reset: rst_n sets the configuration registers to their reset values and clears the run state.
// ----------------------------------------------------------------------------
// RGB color classifier, debounced
// Ambient correction, percent-of-white ratios and ordered class rules with
// a run counter that confirms a class before it is reported.
// ----------------------------------------------------------------------------
`include "rgb_color_classifier_debounced_core_defines.svh"

module rgb_color_classifier_debounced_core import rgbcc_pkg::*; #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    rgbcc_in_if.sink     in_ch,
    rgbcc_out_if.source  out_ch,
    rgbcc_cfg_if.sink    cfg
);

    localparam int NUM_W = SAMPLE_BITS + 7;
    localparam int EXT_W = (NUM_W > RATIO_W) ? NUM_W : RATIO_W + 1;
    localparam int CMP_W = (SAMPLE_BITS > MIN_WHITE_W) ? SAMPLE_BITS : MIN_WHITE_W;
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    state_t                 state_reg, state_next;
    logic [SAMPLE_BITS-1:0] rc_reg, gc_reg, bc_reg, wc_reg;
    logic                   dim_reg, dim_next;
    logic [1:0]             chan_reg, chan_next;
    logic [RATIO_W-1:0]     r_ratio_reg, g_ratio_reg, b_ratio_reg;
    logic [CODE_W-1:0]      prev_class_reg, prev_class_next;
    logic [RUN_W-1:0]       run_cnt_reg, run_cnt_next;
    logic [MIN_WHITE_W-1:0] min_white_reg;
    logic [RUN_W-1:0]       confirm_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]      out_code_reg, out_code_next;

    logic                   in_fire, cfg_fire, out_free;
    logic                   div_start, div_busy, div_done;
    logic [NUM_W-1:0]       div_num, div_quot;
    logic [SAMPLE_BITS-1:0] num_chan, cur_chan;
    logic [EXT_W-1:0]       quot_ext;
    logic [RATIO_W-1:0]     ratio_val;
    logic [CMP_W-1:0]       w_ext;
    logic                   bright;
    logic [PROD_W-1:0]      r_x, g_x, b_x;
    logic [CODE_W-1:0]      cls;
    logic                   matched;
    logic [RUN_W-1:0]       run_upd;

    // handshakes
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign cfg.ready    = 1'b1;
    assign cfg_fire     = cfg.valid && cfg.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.color_code = out_code_reg;

    // brightness check against the programmed floor
    assign w_ext  = CMP_W'(wc_reg);
    assign bright = w_ext >= CMP_W'(min_white_reg);

    // numerator for the channel being started
    always_comb
    begin
        unique case (state_reg)
            S_DIV:   num_chan = (chan_reg == CH_RED) ? gc_reg : bc_reg;
            default: num_chan = rc_reg;
        endcase
    end
    assign div_num   = NUM_W'(num_chan) * NUM_W'(PCT_SCALE);
    assign div_start = ((state_reg == S_PREP) && bright) ||
                       ((state_reg == S_DIV) && div_done && (chan_reg != CH_BLUE));

    rgbcc_div #(
        .NUM_W (NUM_W),
        .DEN_W (SAMPLE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (wc_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // saturate the quotient; zero white gives full scale for a lit channel
    always_comb
    begin
        case (chan_reg)
            CH_RED:   cur_chan = rc_reg;
            CH_GREEN: cur_chan = gc_reg;
            default:  cur_chan = bc_reg;
        endcase
    end
    assign quot_ext = EXT_W'(div_quot);
    always_comb
    begin
        if (wc_reg == '0)
            ratio_val = (cur_chan == '0) ? '0 : RATIO_MAX;
        else if (quot_ext > EXT_W'(RATIO_MAX))
            ratio_val = RATIO_MAX;
        else
            ratio_val = quot_ext[RATIO_W-1:0];
    end

    // class rules, first match wins
    assign r_x = PROD_W'(r_ratio_reg);
    assign g_x = PROD_W'(g_ratio_reg);
    assign b_x = PROD_W'(b_ratio_reg);
    always_comb
    begin
        if (g_x < r_x && (b_x << 1) < r_x)
            cls = CLS_RED;
        else if ((b_x << 1) < r_x && (b_x + (b_x << 1)) < g_x &&
                 w_ext > CMP_W'(YELLOW_MIN_W))
            cls = CLS_YELLOW;
        else if (g_x > (r_x + (r_x << 1)) && (b_x << 1) < g_x &&
                 w_ext < CMP_W'(GREEN_MAX_W))
            cls = CLS_GREEN;
        else if (b_x > (r_x << 1) && (b_x << 2) > (g_x << 1))
            cls = CLS_BLUE;
        else if ((b_x << 1) > r_x && b_x < (r_x << 1) && g_x < (r_x << 2) &&
                 w_ext > CMP_W'(WHITE_MIN_W))
            cls = CLS_WHITE;
        else
            cls = CLS_NONE;
    end

    // run counter update for a matched class
    assign matched = !dim_reg && (cls != CLS_NONE);
    always_comb
    begin
        if (prev_class_reg == cls)
            run_upd = (run_cnt_reg == RUN_MAX) ? RUN_MAX : run_cnt_reg + RUN_W'(1);
        else
            run_upd = '0;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        dim_next        = dim_reg;
        chan_next       = chan_reg;
        prev_class_next = prev_class_reg;
        run_cnt_next    = run_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_code_next   = out_code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                dim_next   = !bright;
                chan_next  = CH_RED;
                state_next = bright ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    chan_next = chan_reg + 2'd1;
                    if (chan_reg == CH_BLUE)
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = CLS_NONE;
                    if (matched)
                    begin
                        prev_class_next = cls;
                        run_cnt_next    = run_upd;
                        if (run_upd > confirm_reg)
                            out_code_next = cls;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dim_reg        <= 1'b0;
            chan_reg       <= CH_RED;
            prev_class_reg <= CLS_NONE;
            run_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dim_reg        <= dim_next;
            chan_reg       <= chan_next;
            prev_class_reg <= prev_class_next;
            run_cnt_reg    <= run_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_white_reg <= MIN_WHITE_RESET;
            confirm_reg   <= CONFIRM_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                CFG_MIN_WHITE:    min_white_reg <= cfg.data[MIN_WHITE_W-1:0];
                CFG_CONFIRM_RUNS: confirm_reg   <= cfg.data[RUN_W-1:0];
                default:          ;
            endcase
        end
    end

    // ambient-corrected samples, clamped at zero
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rc_reg <= (in_ch.red_sample > in_ch.ambient_sample) ?
                      in_ch.red_sample - in_ch.ambient_sample : '0;
            gc_reg <= (in_ch.green_sample > in_ch.ambient_sample) ?
                      in_ch.green_sample - in_ch.ambient_sample : '0;
            bc_reg <= (in_ch.blue_sample > in_ch.ambient_sample) ?
                      in_ch.blue_sample - in_ch.ambient_sample : '0;
            wc_reg <= (in_ch.white_sample > in_ch.ambient_sample) ?
                      in_ch.white_sample - in_ch.ambient_sample : '0;
        end
    end

    // ratio capture
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_done)
        begin
            case (chan_reg)
                CH_RED:   r_ratio_reg <= ratio_val;
                CH_GREEN: g_ratio_reg <= ratio_val;
                default:  b_ratio_reg <= ratio_val;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        out_code_reg <= out_code_next;
    end

    // checks
    `RGBCC_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_start, !div_busy, "divider restarted while busy")
    `RGBCC_ASSERT_IMP(a_run_step, clk, rst_n, run_cnt_reg != $past(run_cnt_reg), (run_cnt_reg == '0) || (run_cnt_reg == $past(run_cnt_reg) + RUN_W'(1)), "run counter jumped")
    `RGBCC_ASSERT_IMP(a_code_prev, clk, rst_n, out_valid_reg && (out_code_reg != CLS_NONE), out_code_reg == prev_class_reg, "reported class differs from run class")
    `RGBCC_ASSERT_NXT(a_accept_done, clk, rst_n, in_fire, state_reg == S_PREP, "accepted reading not sequenced")

endmodule

// ===== hw/rtl/rgbcc_div.sv =====
// ----------------------------------------------------------------------------
// RGB color classifier serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgbcc_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
            rem_next  = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// RGB color classifier testbench
// Drives photodiode reading sets through the input channel, mirrors ambient
// correction, percent-of-white ratios, the ordered class rules and the run
// counter, and checks every color_code transaction against that mirror.
// Register writes happen only while the block is drained.
// ----------------------------------------------------------------------------
module testbench;
    import rgbcc_pkg::*;

    localparam int SAMPLE_BITS    = 10;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int LATENCY        = 3 * (SAMPLE_BITS + 8) + 3;
    localparam int IDLE_GUARD     = 4;
    localparam int WATCHDOG_LIMIT = 4000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CODE_W-1:0]      code_t;

    typedef struct packed {
        sample_t ambient;
        sample_t red;
        sample_t green;
        sample_t blue;
        sample_t white;
    } reading_t;

    logic clk;
    logic rst_n;

    rgbcc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    rgbcc_out_if                             out_ch ();
    rgbcc_cfg_if                             cfg_ch ();

    rgb_color_classifier_debounced_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // mirrored registers and run state
    logic [MIN_WHITE_W-1:0] min_white_q;
    logic [RUN_W-1:0]       confirm_q;
    logic [RUN_W-1:0]       run_count_q;
    code_t                  last_class_q;

    code_t pending_colors[$];
    code_t want_code;
    int    err_count    = 0;
    int    idle_cycles  = 0;
    int    tx_idle_pct  = 25;
    int    rx_stall_pct = 50;

    // ------------------------------------------------------------------------
    // Color predictor
    // ------------------------------------------------------------------------
    function automatic sample_t less_ambient(sample_t v, sample_t amb);
        return (amb > v) ? '0 : sample_t'(v - amb);
    endfunction

    function automatic sample_t white_level(reading_t rd);
        return less_ambient(rd.white, rd.ambient);
    endfunction

    // channel * 100 / white, saturating; zero white gives 0 or full scale
    function automatic longint pct_of_white(sample_t c, sample_t w);
        longint q;
        if (w == 0)
            return (c == 0) ? 0 : longint'(RATIO_MAX);
        q = longint'(c) * PCT_SCALE / longint'(w);
        return (q > longint'(RATIO_MAX)) ? longint'(RATIO_MAX) : q;
    endfunction

    // ordered rules, without the brightness gate
    function automatic code_t rule_class(reading_t rd);
        sample_t wc;
        longint  r;
        longint  g;
        longint  b;
        wc = white_level(rd);
        r  = pct_of_white(less_ambient(rd.red, rd.ambient), wc);
        g  = pct_of_white(less_ambient(rd.green, rd.ambient), wc);
        b  = pct_of_white(less_ambient(rd.blue, rd.ambient), wc);
        if (g < r && 2 * b < r)
            return CLS_RED;
        if (2 * b < r && 3 * b < g && wc > YELLOW_MIN_W)
            return CLS_YELLOW;
        if (g > 3 * r && 2 * b < g && wc < GREEN_MAX_W)
            return CLS_GREEN;
        if (b > 2 * r && 4 * b > 2 * g)
            return CLS_BLUE;
        if (2 * b > r && b < 2 * r && g < 4 * r && wc > WHITE_MIN_W)
            return CLS_WHITE;
        return CLS_NONE;
    endfunction

    // full step: gate, rules, run counter update, debounce
    function automatic code_t predict_color(reading_t rd);
        code_t cls;
        if (white_level(rd) < min_white_q)
            return CLS_NONE;
        cls = rule_class(rd);
        if (cls == CLS_NONE)
            return CLS_NONE;
        if (last_class_q == cls)
        begin
            if (run_count_q != RUN_MAX)
                run_count_q = run_count_q + 1'b1;
        end
        else
        begin
            run_count_q = '0;
        end
        last_class_q = cls;
        return (run_count_q > confirm_q) ? cls : CLS_NONE;
    endfunction

    // ------------------------------------------------------------------------
    // Reading generators
    // ------------------------------------------------------------------------
    function automatic reading_t reading_of(int amb, int r, int g, int b, int w);
        reading_t rd;
        rd.ambient = sample_t'(amb);
        rd.red     = sample_t'(r);
        rd.green   = sample_t'(g);
        rd.blue    = sample_t'(b);
        rd.white   = sample_t'(w);
        return rd;
    endfunction

    // build a reading aimed at one class; CLS_NONE gives raw noise
    function automatic reading_t shape_reading(code_t want);
        reading_t    rd;
        int unsigned w;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned top;
        int unsigned amb;
        int unsigned lo;
        for (int k = 0; k < 20; k++)
        begin
            w = 0;
            r = 0;
            g = 0;
            b = 0;
            case (want)
                CLS_RED:
                begin
                    lo = (min_white_q > 1) ? min_white_q : 1;
                    w  = $urandom_range(SAMPLE_MAX, lo);
                    r  = $urandom_range(w, w / 2);
                    g  = (r == 0) ? 0 : $urandom_range(r - 1, 0);
                    b  = $urandom_range(r / 3, 0);
                end
                CLS_YELLOW:
                begin
                    lo = (min_white_q > YELLOW_MIN_W) ? min_white_q : YELLOW_MIN_W + 1;
                    w  = $urandom_range(SAMPLE_MAX, lo);
                    r  = $urandom_range(w, w / 2);
                    g  = $urandom_range(w, r);
                    b  = $urandom_range((r / 3 < g / 4) ? r / 3 : g / 4, 0);
                end
                CLS_GREEN:
                begin
                    w = $urandom_range(GREEN_MAX_W - 1, min_white_q);
                    g = $urandom_range(w, w / 2);
                    r = $urandom_range(g / 4, 0);
                    b = $urandom_range(g / 3, 0);
                end
                CLS_BLUE:
                begin
                    w = $urandom_range(SAMPLE_MAX, min_white_q);
                    b = $urandom_range(w, w / 2);
                    r = $urandom_range(b / 3, 0);
                    g = $urandom_range(b, 0);
                end
                CLS_WHITE:
                begin
                    lo = (min_white_q > WHITE_MIN_W) ? min_white_q : WHITE_MIN_W + 1;
                    w  = $urandom_range(SAMPLE_MAX, lo);
                    r  = $urandom_range(w, w / 2);
                    b  = $urandom_range(r, r / 2 + 1);
                    g  = $urandom_range(w, r / 2);
                end
                default:
                begin
                    return reading_of($urandom_range(SAMPLE_MAX, 0),
                                      $urandom_range(SAMPLE_MAX, 0),
                                      $urandom_range(SAMPLE_MAX, 0),
                                      $urandom_range(SAMPLE_MAX, 0),
                                      $urandom_range(SAMPLE_MAX, 0));
                end
            endcase
            top = w;
            if (r > top) top = r;
            if (g > top) top = g;
            if (b > top) top = b;
            amb = ($urandom_range(3) == 0) ? 0 : $urandom_range(SAMPLE_MAX - top, 0);
            rd  = reading_of(amb, amb + r, amb + g, amb + b, amb + w);
            if (white_level(rd) >= min_white_q && rule_class(rd) == want)
                return rd;
        end
        return rd;
    endfunction

    // corrected white below the gate; other channels arbitrary; raw noise if the gate is zero
    function automatic reading_t dim_reading();
        int unsigned w;
        int unsigned amb;
        if (min_white_q == 0)
            return shape_reading(CLS_NONE);
        w   = $urandom_range(min_white_q - 1, 0);
        amb = $urandom_range(SAMPLE_MAX - w, 0);
        return reading_of(amb, $urandom_range(SAMPLE_MAX, 0), $urandom_range(SAMPLE_MAX, 0),
                          $urandom_range(SAMPLE_MAX, 0), amb + w);
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_reading(reading_t rd);
        int gap;
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct)
            gap = ($urandom_range(9) == 0) ? $urandom_range(LATENCY + 5, 1)
                                           : $urandom_range(6, 1);
        @(negedge clk);
        repeat (gap)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.ambient_sample <= rd.ambient;
        in_ch.red_sample     <= rd.red;
        in_ch.green_sample   <= rd.green;
        in_ch.blue_sample    <= rd.blue;
        in_ch.white_sample   <= rd.white;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_colors.push_back(predict_color(rd));
    endtask

    // hold the sender until every expected color has come back
    task automatic wait_all_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wait_all_results();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_MIN_WHITE:    min_white_q = value[MIN_WHITE_W-1:0];
            CFG_CONFIRM_RUNS: confirm_q = value[RUN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------
    // reset values, extremes, clamping, each class and a confirmed run
    task automatic test_reset_state();
        send_reading(reading_of(0, 0, 0, 0, 0));
        send_reading(reading_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
        send_reading(reading_of(0, 39, 0, 0, 39));
        send_reading(reading_of(600, 100, 200, 300, 900));
        send_reading(reading_of(0, 40, 10, 5, 40));
        repeat (6) send_reading(shape_reading(CLS_RED));
        send_reading(shape_reading(CLS_YELLOW));
        send_reading(shape_reading(CLS_GREEN));
        send_reading(shape_reading(CLS_BLUE));
        repeat (7) send_reading(shape_reading(CLS_WHITE));
    endtask

    // spare indexes, zero white, ratio saturation, register extremes
    task automatic test_register_writes();
        write_register(CFG_SPARE_2, '1);
        write_register(CFG_SPARE_3, '1);
        send_reading(reading_of(0, 39, 0, 0, 39));
        write_register(CFG_MIN_WHITE, '0);
        write_register(CFG_CONFIRM_RUNS, 10'h300);
        send_reading(reading_of(0, 5, 0, 0, 0));
        send_reading(reading_of(0, 0, 0, 0, 0));
        send_reading(reading_of(0, 5, 0, 0, 0));
        send_reading(reading_of(0, SAMPLE_MAX, 0, 0, 1));
        send_reading(reading_of(0, 0, SAMPLE_MAX, 0, 1));
        send_reading(reading_of(0, 0, 0, SAMPLE_MAX, 1));
        send_reading(reading_of(0, 0, SAMPLE_MAX, SAMPLE_MAX, 1));
        write_register(CFG_MIN_WHITE, '1);
        write_register(CFG_CONFIRM_RUNS, 10'h0FF);
        send_reading(reading_of(0, 900, 900, 900, SAMPLE_MAX));
        send_reading(reading_of(1, 900, 900, 900, SAMPLE_MAX));
        write_register(CFG_MIN_WHITE, MIN_WHITE_RESET);
        write_register(CFG_CONFIRM_RUNS, CFG_DATA_W'(CONFIRM_RESET));
    endtask

    // run counter climbs to its limit and stays there
    task automatic test_counter_saturation();
        write_register(CFG_CONFIRM_RUNS, 10'd254);
        repeat (258) send_reading(shape_reading(CLS_BLUE));
        write_register(CFG_CONFIRM_RUNS, 10'd255);
        repeat (4) send_reading(shape_reading(CLS_BLUE));
        write_register(CFG_CONFIRM_RUNS, CFG_DATA_W'(CONFIRM_RESET));
    endtask

    // runs of one class with random content, mixed with noise and dim readings
    task automatic run_traffic(int n_items);
        int    sent;
        int    len;
        int    pick;
        code_t cls;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                case ($urandom_range(4))
                    0:       cls = CLS_RED;
                    1:       cls = CLS_YELLOW;
                    2:       cls = CLS_GREEN;
                    3:       cls = CLS_BLUE;
                    default: cls = CLS_WHITE;
                endcase
                len = $urandom_range((confirm_q < 10) ? confirm_q + 3 : 6, 1);
                repeat (len) send_reading(shape_reading(cls));
                sent += len;
            end
            else if (pick < 90)
            begin
                send_reading(shape_reading(CLS_NONE));
                sent++;
            end
            else
            begin
                send_reading(dim_reading());
                sent++;
            end
            if ($urandom_range(39) == 0)
                wait_all_results();
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 50 : 0;
            rx_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 25 : 0;
            for (int setting = 0; setting < 3; setting++)
            begin
                case ($urandom_range(9))
                    0:       write_register(CFG_MIN_WHITE, '0);
                    1:       write_register(CFG_MIN_WHITE,
                                            CFG_DATA_W'($urandom_range(SAMPLE_MAX, 0)));
                    default: write_register(CFG_MIN_WHITE, CFG_DATA_W'($urandom_range(79, 1)));
                endcase
                case ($urandom_range(9))
                    0:       write_register(CFG_CONFIRM_RUNS, '0);
                    1:       write_register(CFG_CONFIRM_RUNS, 10'h0FF);
                    default: write_register(CFG_CONFIRM_RUNS, CFG_DATA_W'($urandom_range(8, 1)));
                endcase
                run_traffic(50);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, result side and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_colors.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected color_code %0d", out_ch.color_code));
                end
                else
                begin
                    want_code = pending_colors.pop_front();
                    if (out_ch.color_code !== want_code)
                        report_mismatch($sformatf("color_code %0d, expected %0d",
                                                  out_ch.color_code, want_code));
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.ambient_sample = '0;
        in_ch.red_sample     = '0;
        in_ch.green_sample   = '0;
        in_ch.blue_sample    = '0;
        in_ch.white_sample   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        min_white_q          = MIN_WHITE_RESET;
        confirm_q            = CONFIRM_RESET;
        last_class_q         = CLS_NONE;
        run_count_q          = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_writes();
        test_counter_saturation();
        test_random_traffic();

        wait_all_results();
        repeat (LATENCY) @(posedge clk);
        if (pending_colors.size() != 0)
            report_mismatch($sformatf("%0d colors never arrived", pending_colors.size()));
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== rgb_color_classifier_debounced_core.f =====
+incdir+hw/rtl
hw/rtl/rgbcc_pkg.sv
hw/rtl/rgbcc_if.sv
hw/rtl/rgbcc_div.sv
hw/rtl/rgb_color_classifier_debounced_core.sv
tb/testbench.sv
